[rtl/core/cpft_pkg.sv]
// Shared constants for the complex phase unit: datapath widths, quadrant codes, arctangent table.
package cpft_pkg;

    // Working width of the CORDIC x/y datapath. Magnitudes are placed at bit 56 - DATA_WIDTH,
    // so they stay at or below 2^55, and the vectoring gain keeps them below 2^57.
    localparam int XW = 59;
    // Magnitudes are scaled so that a full-scale input lands just below bit SCALE_TOP.
    localparam int SCALE_TOP = 56;
    // Angle accumulator width; the sum of all table entries stays well below 2^31.
    localparam int ZW = 33;

    // Quadrant of the original sample for the general case.
    localparam logic [1:0] QUAD_1 = 2'd0;
    localparam logic [1:0] QUAD_2 = 2'd1;
    localparam logic [1:0] QUAD_3 = 2'd2;
    localparam logic [1:0] QUAD_4 = 2'd3;

    // Largest clamped angle: a quarter turn in 2^-32 turn units.
    localparam logic [30:0] Z_QUARTER = 31'h4000_0000;

    // atan(2^-i) in units of 2^-32 turn.
    localparam logic [31:0] ATAN_TURNS [0:31] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

endpackage

[rtl/core/complex_phase_full_turn_unit.sv]
// Top level of the complex phase unit: pipelined CORDIC vectoring with a skid output.
//
// Usage: each beat on the s_ channel carries one complex sample (s_real_part, s_imag_part)
// in two's complement. Each beat on the m_ channel carries its phase, m_phase_turns, as an
// unsigned fraction of a full turn. Results come out in the order the samples went in, one
// result per sample. A part whose magnitude is at or below zero_threshold counts as zero;
// the threshold is written through cfg_we/cfg_wdata while no samples are in flight.
// From an accepted input beat to m_valid, a sample passes the stage 0 register (magnitude
// and threshold logic), the CORDIC iteration registers, the register after clamping and
// rounding, the register after the quadrant fold, and the output register. Throughput is one
// sample per clock while s_ready is high; no idle cycles are needed between samples.
// When the receiver stalls, the output register holds its beat and the next finished result
// drops into a one-entry skid register; only once the skid register is full does s_ready
// fall, which freezes every pipeline stage in place so nothing is lost or repeated.
// Reset (aresetn low at a clock edge) empties the pipeline, the output and skid registers,
// and clears zero_threshold to 0.
module complex_phase_full_turn_unit #(
    parameter int DATA_WIDTH  = 16,
    parameter int PHASE_WIDTH = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [14:0]                  cfg_wdata,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [DATA_WIDTH-1:0] s_real_part,
    input  logic signed [DATA_WIDTH-1:0] s_imag_part,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [PHASE_WIDTH-1:0]       m_phase_turns
);

    localparam int XW    = cpft_pkg::XW;
    localparam int ZW    = cpft_pkg::ZW;
    localparam int SCALE = cpft_pkg::SCALE_TOP - DATA_WIDTH;
    // Compare width wide enough for both a magnitude and the 15-bit threshold.
    localparam int CW    = (DATA_WIDTH > 15) ? DATA_WIDTH : 15;
    // Rounding constant: half an output LSB in 2^-32 turn units, none at full precision.
    localparam logic [31:0] RND = (PHASE_WIDTH >= 32) ? 32'd0
                                  : (32'd1 << (31 - (PHASE_WIDTH % 32)));

    localparam logic [PHASE_WIDTH-1:0] HALF    = PHASE_WIDTH'(1) << (PHASE_WIDTH - 1);
    localparam logic [PHASE_WIDTH-1:0] QUARTER = PHASE_WIDTH'(1) << (PHASE_WIDTH - 2);

    // Sideband that travels with each sample: the early-settled answer and the quadrant.
    typedef struct packed {
        logic                   special;
        logic [PHASE_WIDTH-1:0] sp_phase;
        logic [1:0]             quad;
    } side_t;

    // Configuration register.
    logic [14:0] zero_threshold_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zero_threshold_reg <= '0;
        end else if (cfg_we) begin
            zero_threshold_reg <= cfg_wdata;
        end
    end

    // All pipeline stages advance together unless the skid register is holding a result.
    logic skid_valid_reg;
    logic en;

    assign en      = !skid_valid_reg;
    assign s_ready = en;

    // Stage 0: magnitudes, zero tests, quadrant and the scaled CORDIC start vector.
    logic signed [DATA_WIDTH:0]   re_ext;
    logic signed [DATA_WIDTH:0]   im_ext;
    logic signed [DATA_WIDTH:0]   re_abs;
    logic signed [DATA_WIDTH:0]   im_abs;
    logic [DATA_WIDTH-1:0]        are;
    logic [DATA_WIDTH-1:0]        aim;
    logic [CW-1:0]                thr_c;
    logic                         re_zero;
    logic                         im_zero;
    logic                         re_neg;
    logic                         im_neg;
    logic [XW-1:0]                are_w;
    logic [XW-1:0]                aim_w;
    side_t                        side_next;

    assign re_ext  = {s_real_part[DATA_WIDTH-1], s_real_part};
    assign im_ext  = {s_imag_part[DATA_WIDTH-1], s_imag_part};
    assign re_neg  = s_real_part[DATA_WIDTH-1];
    assign im_neg  = s_imag_part[DATA_WIDTH-1];
    assign re_abs  = re_neg ? -re_ext : re_ext;
    assign im_abs  = im_neg ? -im_ext : im_ext;
    assign are     = re_abs[DATA_WIDTH-1:0];
    assign aim     = im_abs[DATA_WIDTH-1:0];
    assign thr_c   = CW'(zero_threshold_reg);
    assign re_zero = CW'(are) <= thr_c;
    assign im_zero = CW'(aim) <= thr_c;
    assign are_w   = XW'(are) << SCALE;
    assign aim_w   = XW'(aim) << SCALE;

    always_comb begin
        side_next.special  = re_zero || im_zero;
        side_next.sp_phase = '0;
        if (re_zero) begin
            if (im_zero) begin
                side_next.sp_phase = '0;
            end else if (!im_neg) begin
                side_next.sp_phase = QUARTER;
            end else begin
                side_next.sp_phase = HALF + QUARTER;
            end
        end else if (re_neg) begin
            side_next.sp_phase = HALF;
        end
        // Used only with both parts nonzero, so a clear sign bit means strictly positive.
        if (!re_neg && !im_neg) begin
            side_next.quad = cpft_pkg::QUAD_1;
        end else if (re_neg && !im_neg) begin
            side_next.quad = cpft_pkg::QUAD_2;
        end else if (re_neg) begin
            side_next.quad = cpft_pkg::QUAD_3;
        end else begin
            side_next.quad = cpft_pkg::QUAD_4;
        end
    end

    // Stage registers: index 0 is the start vector, index i+1 follows iteration i.
    logic                 v_reg    [0:PHASE_WIDTH];
    logic signed [XW-1:0] x_reg    [0:PHASE_WIDTH];
    logic signed [XW-1:0] y_reg    [0:PHASE_WIDTH];
    logic signed [ZW-1:0] z_reg    [0:PHASE_WIDTH];
    side_t                side_reg [0:PHASE_WIDTH];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg[0] <= 1'b0;
        end else if (en) begin
            v_reg[0] <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0]    <= $signed(are_w);
            y_reg[0]    <= $signed(aim_w);
            z_reg[0]    <= '0;
            side_reg[0] <= side_next;
        end
    end

    // One CORDIC vectoring iteration per stage.
    for (genvar i = 0; i < PHASE_WIDTH; i++) begin : g_iter
        logic signed [XW-1:0] dx;
        logic signed [XW-1:0] dy;
        logic signed [ZW-1:0] at;
        logic                 rot_down;

        assign dx       = y_reg[i] >>> i;
        assign dy       = x_reg[i] >>> i;
        assign at       = $signed({1'b0, cpft_pkg::ATAN_TURNS[i]});
        assign rot_down = !y_reg[i][XW-1];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[i+1] <= 1'b0;
            end else if (en) begin
                v_reg[i+1] <= v_reg[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                if (rot_down) begin
                    x_reg[i+1] <= x_reg[i] + dx;
                    y_reg[i+1] <= y_reg[i] - dy;
                    z_reg[i+1] <= z_reg[i] + at;
                end else begin
                    x_reg[i+1] <= x_reg[i] - dx;
                    y_reg[i+1] <= y_reg[i] + dy;
                    z_reg[i+1] <= z_reg[i] - at;
                end
                side_reg[i+1] <= side_reg[i];
            end
        end
    end

    // Clamp the angle to [0, a quarter turn] and round half up to the output width.
    logic signed [ZW-1:0]   z_last;
    logic [30:0]            z_clamp;
    logic [31:0]            z_round;
    logic [PHASE_WIDTH-1:0] a_next;
    logic                   post_v_reg;
    logic [PHASE_WIDTH-1:0] a_reg;
    side_t                  post_side_reg;

    assign z_last = z_reg[PHASE_WIDTH];

    always_comb begin
        if (z_last[ZW-1]) begin
            z_clamp = '0;
        end else if (z_last > $signed({2'b00, cpft_pkg::Z_QUARTER})) begin
            z_clamp = cpft_pkg::Z_QUARTER;
        end else begin
            z_clamp = z_last[30:0];
        end
    end

    assign z_round = {1'b0, z_clamp} + RND;
    assign a_next  = z_round[31 -: PHASE_WIDTH];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            post_v_reg <= 1'b0;
        end else if (en) begin
            post_v_reg <= v_reg[PHASE_WIDTH];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_reg         <= a_next;
            post_side_reg <= side_reg[PHASE_WIDTH];
        end
    end

    // Fold the first-quadrant angle back into the sample's quadrant; wraps modulo a turn.
    logic [PHASE_WIDTH-1:0] fin_next;
    logic                   fin_v_reg;
    logic [PHASE_WIDTH-1:0] fin_reg;

    always_comb begin
        if (post_side_reg.special) begin
            fin_next = post_side_reg.sp_phase;
        end else begin
            case (post_side_reg.quad)
                cpft_pkg::QUAD_1: fin_next = a_reg;
                cpft_pkg::QUAD_2: fin_next = HALF - a_reg;
                cpft_pkg::QUAD_3: fin_next = HALF + a_reg;
                default:          fin_next = '0 - a_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fin_v_reg <= 1'b0;
        end else if (en) begin
            fin_v_reg <= post_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            fin_reg <= fin_next;
        end
    end

    // Output register plus one skid entry. The skid entry catches the result leaving the
    // pipeline while the output register still waits on the receiver.
    logic                   out_valid_reg;
    logic [PHASE_WIDTH-1:0] out_data_reg;
    logic [PHASE_WIDTH-1:0] skid_data_reg;
    logic                   out_free;

    assign out_free = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (out_free) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end else if (out_free) begin
            out_valid_reg <= fin_v_reg;
        end else if (fin_v_reg) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (out_free) begin
                out_data_reg <= skid_data_reg;
            end
        end else if (out_free) begin
            out_data_reg <= fin_reg;
        end else begin
            skid_data_reg <= fin_reg;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_phase_turns = out_data_reg;

    // The skid entry is only ever occupied behind a waiting output beat.
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds a result while the output register is empty");

    // The skid entry fills only when a result left the pipeline into a stalled output.
    a_skid_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_ready && fin_v_reg))
        else $error("skid entry filled without a stalled output");

    // A frozen pipeline keeps its last stage in place.
    a_freeze_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(fin_v_reg) && $stable(fin_reg))
        else $error("last pipeline stage changed while frozen");

    // The clamped, rounded angle never exceeds a quarter turn.
    a_angle_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        post_v_reg |-> (a_reg <= QUARTER))
        else $error("first-quadrant angle exceeds a quarter turn");

endmodule

[test/tb.sv]
// Self-checking testbench for the complex phase unit: directed table, random samples, threshold phases.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // The block is built at its default widths. LATENCY stands for the delay from an accepted
    // sample to its phase beat; the final wait after the drain is sized from it.
    localparam int DW = 16;
    localparam int PW = 16;
    localparam int LATENCY = PW + 4;
    // CYCLE_LIMIT leaves ample room for the slowest correct run, even when both sides
    // wait their longest on every beat and the pipeline is drained between phases.
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_PHASES = 5;
    localparam int SAMPLES_PER_PHASE = 100;

    // One row of the directed part. Where known is set, the phase is read straight off the
    // definition of the block; every other row is checked against the predictor below.
    typedef struct {
        logic [14:0]          thr;
        logic signed [DW-1:0] re;
        logic signed [DW-1:0] im;
        bit                   known;
        logic [PW-1:0]        phase;
    } sample_row_t;

    localparam int DIRECTED_ROWS = 25;

    sample_row_t directed_rows [0:DIRECTED_ROWS-1] = '{
        // Threshold at its reset value of 0: axes, full-scale corners, unit diagonals, near-axis.
        '{15'd0, 16'sd0, 16'sd0, 1'b1, 16'd0},
        '{15'd0, 16'sd100, 16'sd0, 1'b1, 16'd0},
        '{15'd0, -16'sd100, 16'sd0, 1'b1, 16'd32768},
        '{15'd0, 16'sd0, 16'sd100, 1'b1, 16'd16384},
        '{15'd0, 16'sd0, -16'sd100, 1'b1, 16'd49152},
        '{15'd0, 16'sd32767, 16'sd32767, 1'b0, 16'd0},
        '{15'd0, -16'sd32768, -16'sd32768, 1'b0, 16'd0},
        '{15'd0, -16'sd32768, 16'sd32767, 1'b0, 16'd0},
        '{15'd0, 16'sd32767, -16'sd32768, 1'b0, 16'd0},
        '{15'd0, 16'sd1, 16'sd1, 1'b0, 16'd0},
        '{15'd0, -16'sd1, -16'sd1, 1'b0, 16'd0},
        '{15'd0, -16'sd1, 16'sd1, 1'b0, 16'd0},
        '{15'd0, 16'sd1, -16'sd1, 1'b0, 16'd0},
        '{15'd0, 16'sd32767, 16'sd1, 1'b0, 16'd0},
        '{15'd0, 16'sd1, 16'sd32767, 1'b0, 16'd0},
        // A tiny negative angle in the fourth quadrant rounds to a full turn, which wraps.
        '{15'd0, 16'sd32767, -16'sd1, 1'b0, 16'd0},
        '{15'd0, -16'sd32768, 16'sd0, 1'b1, 16'd32768},
        '{15'd0, 16'sd0, -16'sd32768, 1'b1, 16'd49152},
        // Largest threshold: only -32768 stands out of the zero band.
        '{15'd32767, 16'sd32767, -16'sd32767, 1'b1, 16'd0},
        '{15'd32767, -16'sd32768, 16'sd5, 1'b1, 16'd32768},
        '{15'd32767, 16'sd5, -16'sd32768, 1'b1, 16'd49152},
        '{15'd32767, -16'sd32768, -16'sd32768, 1'b0, 16'd0},
        // Threshold of 100: parts exactly at and just above the boundary.
        '{15'd100, 16'sd100, -16'sd101, 1'b1, 16'd49152},
        '{15'd100, 16'sd101, 16'sd101, 1'b0, 16'd0},
        '{15'd100, -16'sd101, 16'sd100, 1'b1, 16'd32768}
    };

    // Clock, reset and the block's inputs all start at known values.
    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [14:0]          cfg_wdata = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic signed [DW-1:0] s_real_part = '0;
    logic signed [DW-1:0] s_imag_part = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [PW-1:0]        m_phase_turns;

    // Phases still owed by the block, oldest first.
    logic [PW-1:0] pending_phases [$];
    // The testbench's own copy of the zero threshold register.
    logic [14:0]   zero_thr = '0;
    // While set, neither side inserts idle cycles, so the pipeline runs back to back.
    bit            idle_free = 1'b0;
    int            mismatch_count = 0;
    int            cycle_count = 0;

    complex_phase_full_turn_unit #(
        .DATA_WIDTH  (DW),
        .PHASE_WIDTH (PW)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_real_part   (s_real_part),
        .s_imag_part   (s_imag_part),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_phase_turns (m_phase_turns)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Watchdog: a run that hangs, or a block that stops answering, ends here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    // Expected phase of one sample. Parts within the threshold count as zero and settle the
    // axis cases directly; everything else goes through a 64-bit CORDIC in vectoring mode on
    // the magnitudes, whose angle is then folded back into the sample's own quadrant.
    function automatic logic [PW-1:0] predict_phase(input logic signed [DW-1:0] re,
                                                    input logic signed [DW-1:0] im,
                                                    input logic [14:0] thr);
        int            mag_re;
        int            mag_im;
        longint        x;
        longint        y;
        longint        z;
        longint        dx;
        longint        dy;
        logic [1:0]    quad;
        logic [PW:0]   full;
        logic [PW:0]   half;
        logic [PW:0]   quarter;
        logic [PW:0]   a;
        logic [PW:0]   ph;
        full    = (PW+1)'(1) << PW;
        half    = full >> 1;
        quarter = full >> 2;
        mag_re  = (re < 0) ? -int'(re) : int'(re);
        mag_im  = (im < 0) ? -int'(im) : int'(im);
        if (mag_re <= int'(thr)) begin
            if (mag_im <= int'(thr)) begin
                ph = '0;
            end else if (im >= 0) begin
                ph = quarter;
            end else begin
                ph = half + quarter;
            end
        end else if (mag_im <= int'(thr)) begin
            ph = (re >= 0) ? '0 : half;
        end else begin
            x = longint'(mag_re) <<< (cpft_pkg::SCALE_TOP - DW);
            y = longint'(mag_im) <<< (cpft_pkg::SCALE_TOP - DW);
            z = 0;
            for (int i = 0; i < PW && i < 32; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (y >= 0) begin
                    x = x + dx;
                    y = y - dy;
                    z = z + longint'(cpft_pkg::ATAN_TURNS[i]);
                end else begin
                    x = x - dx;
                    y = y + dy;
                    z = z - longint'(cpft_pkg::ATAN_TURNS[i]);
                end
            end
            if (z < 0) begin
                z = 0;
            end
            if (z > longint'(cpft_pkg::Z_QUARTER)) begin
                z = longint'(cpft_pkg::Z_QUARTER);
            end
            a = (PW+1)'((z + (longint'(1) << (31 - PW))) >> (32 - PW));
            if (re > 0 && im > 0) begin
                quad = cpft_pkg::QUAD_1;
            end else if (re < 0 && im > 0) begin
                quad = cpft_pkg::QUAD_2;
            end else if (re < 0) begin
                quad = cpft_pkg::QUAD_3;
            end else begin
                quad = cpft_pkg::QUAD_4;
            end
            case (quad)
                cpft_pkg::QUAD_1: begin
                    ph = a;
                end
                cpft_pkg::QUAD_2: begin
                    ph = half - a;
                end
                cpft_pkg::QUAD_3: begin
                    ph = half + a;
                end
                default: begin
                    ph = full - a;
                end
            endcase
        end
        return ph[PW-1:0];
    endfunction

    // Idle cycles before the next beat on either side.
    function automatic int idle_cycles();
        return idle_free ? 0 : int'($urandom_range(0, 5));
    endfunction

    // One random part for a given threshold. Besides fully random words, values land right
    // around the threshold, close to zero, or on the full-scale extremes.
    function automatic logic signed [DW-1:0] random_part(input logic [14:0] thr);
        int mag;
        bit neg;
        logic signed [DW-1:0] v;
        neg = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 4))
            0, 1: begin
                v = DW'($urandom);
            end
            2: begin
                mag = int'(thr) + int'($urandom_range(0, 2)) - 1;
                if (mag < 0) begin
                    mag = 0;
                end
                v = DW'((neg || mag > 32767) ? -mag : mag);
            end
            3: begin
                mag = int'($urandom_range(0, 3));
                v = DW'(neg ? -mag : mag);
            end
            default: begin
                case ($urandom_range(0, 3))
                    0: v = 16'sd32767;
                    1: v = -16'sd32768;
                    2: v = -16'sd32767;
                    default: v = 16'sd0;
                endcase
            end
        endcase
        return v;
    endfunction

    // Drives one sample beat. The task starts right after an edge; valid drops only when an
    // idle gap is drawn, so a back-to-back beat keeps valid high without dropping it in between.
    task automatic send_sample(input logic signed [DW-1:0] re, input logic signed [DW-1:0] im,
                               input logic [PW-1:0] phase);
        int gap;
        gap = idle_cycles();
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_real_part <= re;
        s_imag_part <= im;
        do @(posedge aclk); while (!s_ready);
        pending_phases.push_back(phase);
    endtask

    // Stops sending and waits until every owed phase has come back. Every sample yields a
    // result, so an empty queue means the pipeline is empty as well.
    task automatic drain_pipeline();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_phases.size() != 0) @(negedge aclk);
    endtask

    // Register write while the block is idle; called on a falling edge after a drain.
    task automatic write_threshold(input logic [14:0] thr);
        cfg_we    <= 1'b1;
        cfg_wdata <= thr;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        zero_thr   = thr;
    endtask

    // Result side: a random stall before each beat, then the beat is checked against the
    // oldest expectation. Stalls are drawn even while nothing is in flight, so they fall on
    // every stage of the pipeline's fill and drain.
    initial begin
        int stall;
        logic [PW-1:0] want;
        forever begin
            stall = idle_cycles();
            @(negedge aclk);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            if (pending_phases.size() == 0) begin
                $error("phase_turns: unexpected beat, actual %0d", m_phase_turns);
                mismatch_count++;
            end else begin
                want = pending_phases.pop_front();
                if (m_phase_turns !== want) begin
                    $error("phase_turns: expected %0d, actual %0d", want, m_phase_turns);
                    mismatch_count++;
                end
            end
        end
    end

    // Stimulus: reset, the directed table, then random phases at several thresholds.
    initial begin
        logic [14:0] thr;
        logic signed [DW-1:0] re;
        logic signed [DW-1:0] im;
        logic [PW-1:0] phase;

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed rows. A change of threshold waits for the pipeline to empty first.
        foreach (directed_rows[r]) begin
            if (directed_rows[r].thr != zero_thr) begin
                drain_pipeline();
                write_threshold(directed_rows[r].thr);
            end
            phase = directed_rows[r].known ? directed_rows[r].phase
                  : predict_phase(directed_rows[r].re, directed_rows[r].im, zero_thr);
            send_sample(directed_rows[r].re, directed_rows[r].im, phase);
        end

        // Random phases. Each gets its own threshold, including both extremes, and closes
        // with a stretch in which neither side idles.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: thr = 15'($urandom_range(1, 255));
                1: thr = 15'd0;
                2: thr = 15'($urandom_range(0, 32767));
                3: thr = 15'd32767;
                default: thr = 15'($urandom_range(256, 4095));
            endcase
            drain_pipeline();
            write_threshold(thr);
            for (int k = 0; k < SAMPLES_PER_PHASE; k++) begin
                idle_free = (k >= SAMPLES_PER_PHASE * 7 / 10);
                re = random_part(zero_thr);
                im = random_part(zero_thr);
                send_sample(re, im, predict_phase(re, im, zero_thr));
            end
            idle_free = 1'b0;
        end

        // Let everything come back, then give a stray extra beat time to show up.
        drain_pipeline();
        repeat (2 * LATENCY) @(posedge aclk);
        if (mismatch_count == 0 && pending_phases.size() == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
